/* rtl/tswg_pkg.sv */
package tswg_pkg;

  // Field and register widths
  localparam int CLOCK_HZ_W    = 26;
  localparam int FREQ_W        = 16;
  localparam int DUR_W         = 16;
  localparam int MS_TICK_W     = 16;
  localparam int PERIOD_OUT_W  = 16;
  localparam int DIVISOR_W     = FREQ_W + 1;  // 2 * freq_hz
  localparam int CFG_IDX_W     = 2;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 40;

  localparam int COUNTER_WIDTH_DEF = 16;

  // Register reset values
  localparam logic                  SOUND_EN_RST = 1'b1;
  localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RST = CLOCK_HZ_W'(16000000);
  localparam logic [MS_TICK_W-1:0]  MS_TICK_RST  = MS_TICK_W'(16000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MS_TICK  = 2'd2;

  // Item kinds on in_tuser
  localparam logic FUNC_BEEP = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* rtl/tswg_div.sv */
// Restoring divider, one quotient bit per cycle.
module tswg_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [tswg_pkg::CLOCK_HZ_W-1:0]     dividend,
  input  logic [tswg_pkg::DIVISOR_W-1:0]      divisor,
  output tswg_pkg::div_status_t               status,
  output logic [tswg_pkg::CLOCK_HZ_W-1:0]     quotient
);

  localparam int QW    = tswg_pkg::CLOCK_HZ_W;
  localparam int DW    = tswg_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     dvs_r;
  logic [QW-1:0]     quo_r;

  logic [DW:0]       rem_sh;
  logic [DW:0]       rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, quo_r[QW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

/* rtl/timed_square_wave_tone_generator_unit.sv */
// Timed square-wave tone generator.
//
// Input channel (in_*): each transfer is one item. in_tuser selects the kind:
// 0 is a beep request (freq_hz, tone_ms in in_tdata), 1 is one clock tick.
// Result channel (out_*): exactly one transfer per input item, carrying the
// state after that item (speaker level, tone running, ms left, half period).
// Config channel (cfg_*): index 0 sound enable, 1 clock_hz, 2 ms_tick_cycles;
// other indexes are dropped. cfg_ready is always high; write only when idle.
//
// A tick, a stop request or a request while sound is disabled needs no division,
// so ticks stream at one per clock while the result channel is not stalled. A
// request that starts a tone runs clock_hz / (2 * freq_hz) through the
// bit-serial divider, and in_tready stays low while the division runs.
// The result sits in an output register; the next item is taken in the same
// cycle that register empties. If the receiver stalls, in_tready drops until
// the pending result is taken; nothing is lost or dropped.
// Reset (rst_n low, synchronous) silences the tone, clears counters and
// loads the register defaults (enabled, 16 MHz, 16000 ticks per ms).
module timed_square_wave_tone_generator_unit #(
  parameter int COUNTER_WIDTH = tswg_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tswg_pkg::IN_DATA_W-1:0]      in_tdata,   // [15:0] freq_hz, [31:16] tone_ms
  input  logic                                in_tuser,   // [0] func
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tswg_pkg::OUT_DATA_W-1:0]     out_tdata,  // [0] speaker_out, [1] tone_on_out,
                                                          // [17:2] ms_left_out,
                                                          // [33:18] period_out, [39:34] zero
  // config channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tswg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tswg_pkg::CLOCK_HZ_W-1:0]     cfg_data
);

  localparam int CW   = COUNTER_WIDTH;
  localparam int QW   = tswg_pkg::CLOCK_HZ_W;
  localparam int EW   = (CW > QW) ? CW : QW;     // width for the clamp compare
  localparam int MSW  = tswg_pkg::MS_TICK_W;
  localparam int DRW  = tswg_pkg::DUR_W;
  localparam int FRW  = tswg_pkg::FREQ_W;
  localparam int PW   = tswg_pkg::PERIOD_OUT_W;
  localparam int PADW = tswg_pkg::OUT_DATA_W - (2 + DRW + PW);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // Config registers
  logic                 sound_en_r;
  logic [QW-1:0]        clock_hz_r;
  logic [MSW-1:0]       ms_tick_r;

  // Tone state
  state_t               state_r,     state_nxt;
  logic                 speaker_r,   speaker_nxt;
  logic                 running_r,   running_nxt;
  logic [CW-1:0]        count_r,     count_nxt;
  logic [CW-1:0]        period_r,    period_nxt;
  logic [DRW-1:0]       ms_rem_r,    ms_rem_nxt;
  logic [MSW-1:0]       ms_div_r,    ms_div_nxt;
  logic [DRW-1:0]       dur_pend_r,  dur_pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [tswg_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                 accept;
  logic                 load_out;
  logic                 div_start;
  logic [FRW-1:0]       in_freq;
  logic [DRW-1:0]       in_dur;
  logic                 ms_event;

  tswg_pkg::div_status_t div_stat;
  logic [QW-1:0]        quotient;
  logic [QW-1:0]        q_m1;
  logic [EW-1:0]        q_m1_ext;
  logic [CW-1:0]        half_period;

  assign in_freq   = in_tdata[FRW-1:0];
  assign in_dur    = in_tdata[FRW +: DRW];
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Divider: clock_hz / (2 * freq_hz)
  tswg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clock_hz_r),
    .divisor  ({in_freq, 1'b0}),
    .status   (div_stat),
    .quotient (quotient)
  );

  // Half period: q - 1, clamped; a zero quotient clamps too
  assign q_m1     = quotient - 1'b1;
  assign q_m1_ext = EW'(q_m1);
  always_comb begin
    if (quotient == '0) begin
      half_period = '1;
    end else if (q_m1_ext > EW'({CW{1'b1}})) begin
      half_period = '1;
    end else begin
      half_period = CW'(q_m1_ext);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    speaker_nxt   = speaker_r;
    running_nxt   = running_r;
    count_nxt     = count_r;
    period_nxt    = period_r;
    ms_rem_nxt    = ms_rem_r;
    ms_div_nxt    = ms_div_r;
    dur_pend_nxt  = dur_pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    load_out      = 1'b0;
    div_start     = 1'b0;
    ms_event      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == tswg_pkg::FUNC_TICK) begin
            load_out = 1'b1;
            // tone counter first
            if (running_r) begin
              if (count_r == period_r) begin
                count_nxt   = '0;
                speaker_nxt = !speaker_r;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
            // free-running millisecond divider
            if (ms_div_r == '0) begin
              ms_div_nxt = (ms_tick_r == '0) ? '0 : ms_tick_r - 1'b1;
              ms_event   = 1'b1;
            end else begin
              ms_div_nxt = ms_div_r - 1'b1;
            end
            if (ms_event && ms_rem_r != '0) begin
              ms_rem_nxt = ms_rem_r - 1'b1;
              if (ms_rem_r == DRW'(1)) begin
                running_nxt = 1'b0;
                speaker_nxt = 1'b0;
              end
            end
          end else if (!sound_en_r) begin
            load_out = 1'b1;
          end else if (in_freq == '0 || in_dur == '0) begin
            // stop request
            load_out    = 1'b1;
            running_nxt = 1'b0;
            speaker_nxt = 1'b0;
            ms_rem_nxt  = '0;
          end else begin
            div_start    = 1'b1;
            dur_pend_nxt = in_dur;
            state_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          load_out    = 1'b1;
          count_nxt   = '0;
          period_nxt  = half_period;
          running_nxt = 1'b1;
          ms_rem_nxt  = dur_pend_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{PADW{1'b0}}, PW'(period_nxt), ms_rem_nxt, running_nxt, speaker_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      speaker_r   <= 1'b0;
      running_r   <= 1'b0;
      count_r     <= '0;
      period_r    <= '0;
      ms_rem_r    <= '0;
      ms_div_r    <= '0;
      dur_pend_r  <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      speaker_r   <= speaker_nxt;
      running_r   <= running_nxt;
      count_r     <= count_nxt;
      period_r    <= period_nxt;
      ms_rem_r    <= ms_rem_nxt;
      ms_div_r    <= ms_div_nxt;
      dur_pend_r  <= dur_pend_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_en_r <= tswg_pkg::SOUND_EN_RST;
      clock_hz_r <= tswg_pkg::CLOCK_HZ_RST;
      ms_tick_r  <= tswg_pkg::MS_TICK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tswg_pkg::REG_SOUND_EN: sound_en_r <= cfg_data[0];
        tswg_pkg::REG_CLOCK_HZ: clock_hz_r <= cfg_data;
        tswg_pkg::REG_MS_TICK:  ms_tick_r  <= cfg_data[MSW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Silence whenever the tone is off
  a_off_is_low: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> !speaker_r)
    else $error("speaker high while tone is off");

  // Tone runs exactly while milliseconds remain
  a_run_vs_ms: assert property (@(posedge clk) disable iff (!rst_n)
    running_r == (ms_rem_r != '0))
    else $error("tone running state disagrees with ms countdown");

  // Tone counter never passes the compare value
  a_count_le_period: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= period_r)
    else $error("tone counter beyond half period");

  // Divider only works while the sequencer waits for it
  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> state_r == ST_DIV)
    else $error("divider active outside the divide state");

  // A finished division always shows a registered result in the next cycle
  a_div_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |=> out_valid_r && running_r)
    else $error("divide completion did not produce a result");

endmodule
